FILE: src/ssm_pkg.sv
// shared types and constants for the spi save memory chip
// no dependencies; used by every module of the block but the queue
package ssm_pkg;

    localparam logic [1:0] CHIP_NONE   = 2'd0;
    localparam logic [1:0] CHIP_TINY   = 2'd1;
    localparam logic [1:0] CHIP_EEPROM = 2'd2;
    localparam logic [1:0] CHIP_FLASH  = 2'd3;

    localparam logic [1:0] REG_CHIP_TYPE = 2'd0;
    localparam logic [1:0] REG_SIZE_LOG2 = 2'd1;
    localparam logic [1:0] REG_PROG_AND  = 2'd2;

    localparam logic [7:0] CMD_WRSR      = 8'h01;
    localparam logic [7:0] CMD_WRITE     = 8'h02;
    localparam logic [7:0] CMD_READ      = 8'h03;
    localparam logic [7:0] CMD_WRDI      = 8'h04;
    localparam logic [7:0] CMD_RDSR      = 8'h05;
    localparam logic [7:0] CMD_WREN      = 8'h06;
    localparam logic [7:0] CMD_WRITE_HI  = 8'h0A;
    localparam logic [7:0] CMD_READ_HI   = 8'h0B;
    localparam logic [7:0] CMD_SEC_ERASE = 8'hD8;
    localparam logic [7:0] CMD_PG_ERASE  = 8'hDB;

    localparam logic [7:0] STATUS_WEL = 8'h02;
    localparam logic [7:0] STATUS_WRMASK = 8'h0C;
    localparam logic [7:0] TINY_STATUS_OR = 8'hF0;
    localparam logic [8:0] TINY_HIGH = 9'h100;
    localparam logic [4:0] SIZE_MIN = 5'd9;
    localparam logic [4:0] SIZE_MAX = 5'd26;
    localparam int ADDR_W = 24;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE,
        OP_AND,
        OP_ERASE
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       sector;
    } cmd_t;

endpackage

FILE: src/ssm_front.sv
// front end: command decode, address and status tracking, memory op classification
// depends on ssm_pkg
module ssm_front #(
    parameter int MEM_BYTES    = 65536,
    parameter int SECTOR_BYTES = 65536,
    parameter int PAGE_BYTES   = 256,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            mode,
    input  logic [7:0]      data_in,
    input  logic [1:0]      chip_type,
    input  logic [4:0]      size_log2,
    input  logic            program_ands_bits,
    output logic [AW-1:0]   mask,
    output ssm_pkg::cmd_t   push_cmd,
    output logic [AW-1:0]   push_idx
);

    localparam int XW = (AW > ssm_pkg::ADDR_W) ? AW : ssm_pkg::ADDR_W;
    localparam logic [23:0] SEC_STEP = 24'(SECTOR_BYTES);
    localparam logic [23:0] PG_STEP  = 24'(PAGE_BYTES);

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [23:0] addr_reg, addr_next;
    logic [7:0]  status_reg, status_next;

    logic [4:0]    s_clamp;
    logic [XW-1:0] mask_x;
    logic [XW-1:0] ax_cur;
    logic [XW-1:0] ax_sh;
    logic [AW-1:0] idx_cur;
    logic [AW-1:0] idx_sh;
    logic [AW-1:0] idx_tiny;
    logic [8:0]    tiny_sum;
    logic [23:0]   addr_sh;
    logic [23:0]   addr_inc;
    logic [7:0]    pos_inc;
    logic [7:0]    status_wr;
    logic          wel;
    logic          big;
    logic          addressing;
    logic          tiny_hi;

    always_comb
    begin
        if (size_log2 < ssm_pkg::SIZE_MIN)
            s_clamp = ssm_pkg::SIZE_MIN;
        else if (size_log2 > ssm_pkg::SIZE_MAX)
            s_clamp = ssm_pkg::SIZE_MAX;
        else
            s_clamp = size_log2;
        for (int i = 0; i < AW; i++)
        begin
            mask[i] = (5'(i) < s_clamp);
        end
    end

    assign mask_x    = XW'(mask);
    assign big       = mask_x[16];
    assign addr_sh   = {addr_reg[15:0], data_in};
    assign addr_inc  = addr_reg + 24'd1;
    assign ax_cur    = XW'(addr_reg);
    assign ax_sh     = XW'(addr_sh);
    assign idx_cur   = ax_cur[AW-1:0] & mask;
    assign idx_sh    = ax_sh[AW-1:0] & mask;
    assign tiny_hi   = (cmd_reg == ssm_pkg::CMD_WRITE_HI) || (cmd_reg == ssm_pkg::CMD_READ_HI);
    assign tiny_sum  = addr_reg[8:0] + (tiny_hi ? ssm_pkg::TINY_HIGH : 9'h000);
    assign idx_tiny  = AW'(tiny_sum) & mask;
    assign pos_inc   = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;
    assign wel       = (status_reg & ssm_pkg::STATUS_WEL) != 8'h00;
    assign status_wr = (pos_reg == 8'd1)
                     ? ((status_reg & 8'h01) | (data_in & ssm_pkg::STATUS_WRMASK))
                     : status_reg;
    assign addressing = (pos_reg <= 8'd3) &&
        ((cmd_reg == ssm_pkg::CMD_WRITE) || (cmd_reg == ssm_pkg::CMD_READ) ||
         (cmd_reg == ssm_pkg::CMD_WRITE_HI) || (cmd_reg == ssm_pkg::CMD_READ_HI) ||
         (cmd_reg == ssm_pkg::CMD_SEC_ERASE) || (cmd_reg == ssm_pkg::CMD_PG_ERASE));

    always_comb
    begin
        pos_next    = pos_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        status_next = status_reg;
        push_cmd.kind   = ssm_pkg::OP_NONE;
        push_cmd.data   = 8'h00;
        push_cmd.sector = 1'b0;
        push_idx        = idx_cur;
        if (mode)
        begin
            pos_next = 8'd0;
        end
        else if (chip_type != ssm_pkg::CHIP_NONE)
        begin
            pos_next = pos_inc;
            if (pos_reg == 8'd0)
            begin
                if (data_in == ssm_pkg::CMD_WRDI)
                    status_next = status_reg & ~ssm_pkg::STATUS_WEL;
                else if (data_in == ssm_pkg::CMD_WREN)
                    status_next = status_reg | ssm_pkg::STATUS_WEL;
                else
                begin
                    cmd_next = data_in;
                    addr_next = 24'd0;
                    push_cmd.data = 8'hFF;
                end
            end
            else if (chip_type == ssm_pkg::CHIP_TINY)
            begin
                push_idx = idx_tiny;
                case (cmd_reg)
                    ssm_pkg::CMD_WRSR:
                        status_next = status_wr;
                    ssm_pkg::CMD_RDSR:
                        push_cmd.data = status_reg | ssm_pkg::TINY_STATUS_OR;
                    ssm_pkg::CMD_WRITE, ssm_pkg::CMD_WRITE_HI:
                    begin
                        if (pos_reg < 8'd2)
                            addr_next = 24'(data_in);
                        else
                        begin
                            if (wel)
                            begin
                                push_cmd.kind = ssm_pkg::OP_WRITE;
                                push_cmd.data = data_in;
                            end
                            addr_next = addr_inc;
                        end
                    end
                    ssm_pkg::CMD_READ, ssm_pkg::CMD_READ_HI:
                    begin
                        if (pos_reg < 8'd2)
                            addr_next = 24'(data_in);
                        else
                        begin
                            push_cmd.kind = ssm_pkg::OP_READ;
                            addr_next = addr_inc;
                        end
                    end
                    default:
                        push_cmd.data = 8'hFF;
                endcase
            end
            else if (chip_type == ssm_pkg::CHIP_EEPROM)
            begin
                case (cmd_reg)
                    ssm_pkg::CMD_WRSR:
                        status_next = status_wr;
                    ssm_pkg::CMD_RDSR:
                        push_cmd.data = status_reg;
                    ssm_pkg::CMD_WRITE:
                    begin
                        if (pos_reg <= (big ? 8'd3 : 8'd2))
                            addr_next = addr_sh;
                        else
                        begin
                            if (wel)
                            begin
                                push_cmd.kind = ssm_pkg::OP_WRITE;
                                push_cmd.data = data_in;
                            end
                            addr_next = addr_inc;
                        end
                    end
                    ssm_pkg::CMD_READ:
                    begin
                        if (pos_reg <= (big ? 8'd3 : 8'd2))
                            addr_next = addr_sh;
                        else
                        begin
                            push_cmd.kind = ssm_pkg::OP_READ;
                            addr_next = addr_inc;
                        end
                    end
                    default:
                        push_cmd.data = 8'hFF;
                endcase
            end
            else
            begin
                if (addressing)
                    addr_next = addr_sh;
                case (cmd_reg)
                    ssm_pkg::CMD_RDSR:
                        push_cmd.data = status_reg;
                    ssm_pkg::CMD_WRITE, ssm_pkg::CMD_WRITE_HI:
                    begin
                        if (!addressing)
                        begin
                            if (wel)
                            begin
                                push_cmd.kind = (cmd_reg == ssm_pkg::CMD_WRITE && program_ands_bits)
                                              ? ssm_pkg::OP_AND : ssm_pkg::OP_WRITE;
                                push_cmd.data = data_in;
                            end
                            addr_next = addr_inc;
                        end
                    end
                    ssm_pkg::CMD_READ:
                    begin
                        if (!addressing)
                        begin
                            push_cmd.kind = ssm_pkg::OP_READ;
                            addr_next = addr_inc;
                        end
                    end
                    ssm_pkg::CMD_READ_HI:
                    begin
                        if (!addressing && pos_reg != 8'd4)
                        begin
                            push_cmd.kind = ssm_pkg::OP_READ;
                            addr_next = addr_inc;
                        end
                    end
                    ssm_pkg::CMD_SEC_ERASE, ssm_pkg::CMD_PG_ERASE:
                    begin
                        if (pos_reg == 8'd3 && wel)
                        begin
                            push_cmd.kind = ssm_pkg::OP_ERASE;
                            push_cmd.sector = (cmd_reg == ssm_pkg::CMD_SEC_ERASE);
                            push_idx = idx_sh;
                            addr_next = addr_sh +
                                ((cmd_reg == ssm_pkg::CMD_SEC_ERASE) ? SEC_STEP : PG_STEP);
                        end
                    end
                    default:
                        push_cmd.data = 8'hFF;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            cmd_reg    <= 8'd0;
            addr_reg   <= 24'd0;
            status_reg <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            cmd_reg    <= cmd_next;
            addr_reg   <= addr_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: src/ssm_queue.sv
// two-entry queue between the decode front and the memory back end
// depends on nothing
module ssm_queue #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    output logic         valid,
    input  logic         pop,
    output logic [W-1:0] dout
);

    logic [W-1:0] ent_reg [2];
    logic [1:0]   count_reg, count_next;
    logic         wp_reg;
    logic         rp_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign dout  = ent_reg[rp_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= din;
    end

endmodule

FILE: src/ssm_back.sv
// back end: save memory array, read, write, program-and, erase walk, clearing pass
// depends on ssm_pkg
module ssm_back #(
    parameter int MEM_BYTES    = 65536,
    parameter int SECTOR_BYTES = 65536,
    parameter int PAGE_BYTES   = 256,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ssm_pkg::cmd_t   q_cmd,
    input  logic [AW-1:0]   q_idx,
    output logic            pop,
    input  logic [AW-1:0]   mask,
    output logic            clearing,
    output logic            done,
    output logic [7:0]      data_out,
    output logic            stored
);

    localparam int WW = (AW < ssm_pkg::ADDR_W) ? AW : ssm_pkg::ADDR_W;
    localparam logic [AW-1:0] WRAP = {AW{1'b1}} >> (AW - WW);
    localparam int ERASE_MAX = (SECTOR_BYTES > PAGE_BYTES) ? SECTOR_BYTES : PAGE_BYTES;
    localparam int EW = $clog2(ERASE_MAX) + 1;
    localparam logic [EW-1:0] SEC_CNT = EW'(SECTOR_BYTES);
    localparam logic [EW-1:0] PG_CNT  = EW'(PAGE_BYTES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_AND,
        ST_ERASE
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] cur_idx_reg;
    logic [7:0]    cur_data_reg;
    logic [EW-1:0] rem_reg;
    logic          done_reg;
    logic [7:0]    dout_reg;
    logic          stored_reg;

    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    rd_q;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] idx_step;

    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign clearing = (state_reg == ST_CLEAR);
    assign done     = done_reg;
    assign data_out = dout_reg;
    assign stored   = stored_reg;
    assign idx_step = ((cur_idx_reg + AW'(1)) & WRAP) & mask;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = cur_idx_reg;
        mem_wdata = 8'hFF;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            ST_IDLE:
            begin
                mem_addr  = q_idx;
                mem_we    = pop && (q_cmd.kind == ssm_pkg::OP_WRITE);
                mem_wdata = q_cmd.data;
            end
            ST_READ:
                mem_we = 1'b0;
            ST_AND:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_q & cur_data_reg;
            end
            ST_ERASE:
                mem_we = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_q <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cur_idx_reg  <= '0;
            cur_data_reg <= 8'd0;
            rem_reg      <= '0;
            done_reg     <= 1'b0;
            dout_reg     <= 8'd0;
            stored_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == {AW{1'b1}})
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cur_idx_reg  <= q_idx;
                        cur_data_reg <= q_cmd.data;
                        unique case (q_cmd.kind)
                            ssm_pkg::OP_NONE:
                            begin
                                done_reg   <= 1'b1;
                                dout_reg   <= q_cmd.data;
                                stored_reg <= 1'b0;
                            end
                            ssm_pkg::OP_WRITE:
                            begin
                                done_reg   <= 1'b1;
                                dout_reg   <= 8'd0;
                                stored_reg <= 1'b1;
                            end
                            ssm_pkg::OP_READ:
                                state_reg <= ST_READ;
                            ssm_pkg::OP_AND:
                                state_reg <= ST_AND;
                            ssm_pkg::OP_ERASE:
                            begin
                                state_reg <= ST_ERASE;
                                rem_reg   <= q_cmd.sector ? SEC_CNT : PG_CNT;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                dout_reg   <= 8'd0;
                                stored_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    done_reg   <= 1'b1;
                    dout_reg   <= rd_q;
                    stored_reg <= 1'b0;
                    state_reg  <= ST_IDLE;
                end
                ST_AND:
                begin
                    done_reg   <= 1'b1;
                    dout_reg   <= 8'd0;
                    stored_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                ST_ERASE:
                begin
                    cur_idx_reg <= idx_step;
                    rem_reg     <= rem_reg - EW'(1);
                    if (rem_reg == EW'(1))
                    begin
                        done_reg   <= 1'b1;
                        dout_reg   <= 8'd0;
                        stored_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

FILE: src/spi_save_memory_chip_top.sv
// spi save memory chip: one beat in, one beat out; register port and sub-block wiring
// the queue takes each accepted beat; the back end answers status, command and write beats on
// the pop, reads and flash program-and from ST_READ or ST_AND, erases after their walk
// throughput: one beat a cycle while busy is low; busy rises while two beats wait, so an erase
// stalls input until its walk ends; results cannot be stalled
// reset: control state clears at once, then a clearing pass fills memory with 0xFF
module spi_save_memory_chip_top #(
    parameter int MEM_BYTES    = 65536,
    parameter int SECTOR_BYTES = 65536,
    parameter int PAGE_BYTES   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  data_in,
    output logic        done,
    output logic [7:0]  data_out,
    output logic        stored
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int QW = $bits(ssm_pkg::cmd_t) + AW;

    logic [1:0] chip_type_reg;
    logic [4:0] size_log2_reg;
    logic       prog_and_reg;

    logic          accept;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    logic          clearing;
    logic [AW-1:0] mask;
    ssm_pkg::cmd_t push_cmd;
    logic [AW-1:0] push_idx;
    logic [QW-1:0] q_dout;
    ssm_pkg::cmd_t q_cmd;
    logic [AW-1:0] q_idx;

    assign pready = 1'b1;
    assign busy   = q_full || clearing;
    assign accept = start && !busy;
    assign q_cmd  = ssm_pkg::cmd_t'(q_dout[QW-1:AW]);
    assign q_idx  = q_dout[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_type_reg <= ssm_pkg::CHIP_EEPROM;
            size_log2_reg <= 5'd16;
            prog_and_reg  <= 1'b1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                ssm_pkg::REG_CHIP_TYPE: chip_type_reg <= pwdata[1:0];
                ssm_pkg::REG_SIZE_LOG2: size_log2_reg <= pwdata[4:0];
                ssm_pkg::REG_PROG_AND:  prog_and_reg  <= pwdata[0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ssm_pkg::REG_CHIP_TYPE: prdata = 32'(chip_type_reg);
            ssm_pkg::REG_SIZE_LOG2: prdata = 32'(size_log2_reg);
            ssm_pkg::REG_PROG_AND:  prdata = 32'(prog_and_reg);
            default:                prdata = 32'd0;
        endcase
    end

    ssm_front #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .mode              (mode),
        .data_in           (data_in),
        .chip_type         (chip_type_reg),
        .size_log2         (size_log2_reg),
        .program_ands_bits (prog_and_reg),
        .mask              (mask),
        .push_cmd          (push_cmd),
        .push_idx          (push_idx)
    );

    ssm_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   ({push_cmd, push_idx}),
        .full  (q_full),
        .valid (q_valid),
        .pop   (pop),
        .dout  (q_dout)
    );

    ssm_back #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_idx    (q_idx),
        .pop      (pop),
        .mask     (mask),
        .clearing (clearing),
        .done     (done),
        .data_out (data_out),
        .stored   (stored)
    );

endmodule

FILE: tb/save_chip_checker.sv
// save memory chip checker: watches the register port and the beat channels,
// predicts each answer from its own copy of chip state and compares it
// depends on ssm_pkg for chip types, register indexes and command codes
`timescale 1ns / 100ps

module save_chip_checker #(
    parameter int MEM_BYTES    = 65536,
    parameter int SECTOR_BYTES = 65536,
    parameter int PAGE_BYTES   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [7:0]  data_in,
    input  logic        done,
    input  logic [7:0]  data_out,
    input  logic        stored,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          dirty
);

    typedef struct packed {
        logic [7:0] data;
        logic       stored;
    } answer_t;

    answer_t answer_q[$];

    logic [1:0]  chip_cfg;
    logic [4:0]  size_cfg;
    logic        and_cfg;
    logic [7:0]  pos;
    logic [7:0]  cmd;
    logic [23:0] addr;
    logic [7:0]  status;
    logic [7:0]  mem [0:MEM_BYTES-1];
    logic        wrote;

    function automatic void erase_run(input int unsigned count, input logic [31:0] msk);
        for (int unsigned k = 0; k < count; k++)
        begin
            mem[addr & msk] = 8'hFF;
            addr = addr + 24'd1;
        end
        wrote = 1'b1;
    endfunction

    function automatic answer_t chip_respond(input logic m, input logic [7:0] v);
        answer_t     a;
        logic [31:0] s;
        logic [31:0] msk;
        logic [31:0] asz;
        logic [31:0] hi;
        logic [31:0] idx;
        logic        addressing;
        logic        wel;
        a.data = 8'h00;
        wrote = 1'b0;
        s = 32'(size_cfg);
        if (s < 32'(ssm_pkg::SIZE_MIN))
            s = 32'(ssm_pkg::SIZE_MIN);
        if (s > 32'(ssm_pkg::SIZE_MAX))
            s = 32'(ssm_pkg::SIZE_MAX);
        msk = ((32'd1 << s) - 32'd1) & 32'(MEM_BYTES - 1);
        asz = (msk > 32'hFFFF) ? 32'd3 : 32'd2;
        wel = (status & ssm_pkg::STATUS_WEL) != 8'd0;
        if (m)
        begin
            pos = 8'd0;
        end
        else if (chip_cfg != ssm_pkg::CHIP_NONE)
        begin
            if (pos == 8'd0)
            begin
                if (v == ssm_pkg::CMD_WRDI)
                    status = status & ~ssm_pkg::STATUS_WEL;
                else if (v == ssm_pkg::CMD_WREN)
                    status = status | ssm_pkg::STATUS_WEL;
                else
                begin
                    cmd = v;
                    addr = '0;
                    a.data = 8'hFF;
                end
            end
            else if (chip_cfg == ssm_pkg::CHIP_TINY)
            begin
                hi = (cmd == ssm_pkg::CMD_WRITE_HI || cmd == ssm_pkg::CMD_READ_HI)
                   ? 32'(ssm_pkg::TINY_HIGH) : 32'd0;
                case (cmd)
                    ssm_pkg::CMD_WRSR:
                        if (pos == 8'd1)
                            status = (status & 8'h01) | (v & ssm_pkg::STATUS_WRMASK);
                    ssm_pkg::CMD_RDSR:
                        a.data = status | ssm_pkg::TINY_STATUS_OR;
                    ssm_pkg::CMD_WRITE, ssm_pkg::CMD_WRITE_HI,
                    ssm_pkg::CMD_READ, ssm_pkg::CMD_READ_HI:
                        if (pos < 8'd2)
                            addr = {16'd0, v};
                        else
                        begin
                            idx = ((32'(addr) + hi) & 32'h1FF) & msk;
                            if (cmd == ssm_pkg::CMD_READ || cmd == ssm_pkg::CMD_READ_HI)
                                a.data = mem[idx];
                            else if (wel)
                            begin
                                mem[idx] = v;
                                wrote = 1'b1;
                            end
                            addr = addr + 24'd1;
                        end
                    default:
                        a.data = 8'hFF;
                endcase
            end
            else if (chip_cfg == ssm_pkg::CHIP_EEPROM)
            begin
                case (cmd)
                    ssm_pkg::CMD_WRSR:
                        if (pos == 8'd1)
                            status = (status & 8'h01) | (v & ssm_pkg::STATUS_WRMASK);
                    ssm_pkg::CMD_RDSR:
                        a.data = status;
                    ssm_pkg::CMD_WRITE, ssm_pkg::CMD_READ:
                        if (32'(pos) <= asz)
                            addr = {addr[15:0], v};
                        else
                        begin
                            idx = 32'(addr) & msk;
                            if (cmd == ssm_pkg::CMD_READ)
                                a.data = mem[idx];
                            else if (wel)
                            begin
                                mem[idx] = v;
                                wrote = 1'b1;
                            end
                            addr = addr + 24'd1;
                        end
                    default:
                        a.data = 8'hFF;
                endcase
            end
            else
            begin
                addressing = pos <= 8'd3 &&
                    (cmd == ssm_pkg::CMD_WRITE || cmd == ssm_pkg::CMD_READ ||
                     cmd == ssm_pkg::CMD_WRITE_HI || cmd == ssm_pkg::CMD_READ_HI ||
                     cmd == ssm_pkg::CMD_SEC_ERASE || cmd == ssm_pkg::CMD_PG_ERASE);
                if (addressing)
                    addr = {addr[15:0], v};
                idx = 32'(addr) & msk;
                case (cmd)
                    ssm_pkg::CMD_RDSR:
                        a.data = status;
                    ssm_pkg::CMD_WRITE, ssm_pkg::CMD_WRITE_HI:
                        if (!addressing)
                        begin
                            if (wel)
                            begin
                                mem[idx] = (cmd == ssm_pkg::CMD_WRITE && and_cfg)
                                         ? (mem[idx] & v) : v;
                                wrote = 1'b1;
                            end
                            addr = addr + 24'd1;
                        end
                    ssm_pkg::CMD_READ, ssm_pkg::CMD_READ_HI:
                        if (!addressing && !(cmd == ssm_pkg::CMD_READ_HI && pos == 8'd4))
                        begin
                            a.data = mem[idx];
                            addr = addr + 24'd1;
                        end
                    ssm_pkg::CMD_SEC_ERASE:
                        if (pos == 8'd3 && wel)
                            erase_run(SECTOR_BYTES, msk);
                    ssm_pkg::CMD_PG_ERASE:
                        if (pos == 8'd3 && wel)
                            erase_run(PAGE_BYTES, msk);
                    default:
                        a.data = 8'hFF;
                endcase
            end
            if (pos != 8'd255)
                pos = pos + 8'd1;
        end
        a.stored = wrote;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t     want;
        logic [31:0] reg_val;
        int          k;
        if (!rst_n)
        begin
            chip_cfg = ssm_pkg::CHIP_EEPROM;
            size_cfg = 5'd16;
            and_cfg = 1'b1;
            pos = '0;
            cmd = '0;
            addr = '0;
            status = '0;
            for (k = 0; k < MEM_BYTES; k++)
                mem[k] = 8'hFF;
            answer_q.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, actual data %h stored %b",
                        $time, data_out, stored);
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (data_out !== want.data)
                    begin
                        $display("%0t: data_out mismatch: expected %h, actual %h",
                            $time, want.data, data_out);
                        errors++;
                    end
                    if (stored !== want.stored)
                    begin
                        $display("%0t: stored mismatch: expected %b, actual %b",
                            $time, want.stored, stored);
                        errors++;
                    end
                    checked++;
                    if (want.stored)
                        dirty++;
                end
            end
            if (start && !busy)
                answer_q.insert(answer_q.size(), chip_respond(mode, data_in));
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr)
                        {ssm_pkg::REG_CHIP_TYPE, 2'b00}: chip_cfg = pwdata[1:0];
                        {ssm_pkg::REG_SIZE_LOG2, 2'b00}: size_cfg = pwdata[4:0];
                        {ssm_pkg::REG_PROG_AND, 2'b00}:  and_cfg = pwdata[0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr)
                        {ssm_pkg::REG_CHIP_TYPE, 2'b00}: reg_val = 32'(chip_cfg);
                        {ssm_pkg::REG_SIZE_LOG2, 2'b00}: reg_val = 32'(size_cfg);
                        {ssm_pkg::REG_PROG_AND, 2'b00}:  reg_val = 32'(and_cfg);
                        default:                         reg_val = prdata;
                    endcase
                    if (prdata !== reg_val)
                    begin
                        $display("%0t: register %h readback: expected %h, actual %h",
                            $time, paddr, reg_val, prdata);
                        errors++;
                    end
                end
            end
            pending = answer_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// testbench top for the spi save memory chip: clock, reset, register setup and beat stimulus
// depends on ssm_pkg, spi_save_memory_chip_top and save_chip_checker
`timescale 1ns / 100ps

module tb;

    localparam int MEM_BYTES    = 65536;
    localparam int SECTOR_BYTES = 65536;
    localparam int PAGE_BYTES   = 256;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = 1'b0;
    logic [7:0]  data_in = '0;
    logic        done;
    logic [7:0]  data_out;
    logic        stored;

    int errors;
    int pending;
    int checked;
    int dirty;

    int          idle_pct = 0;
    int          beats = 0;
    int          settings = 0;
    int          sector_left = 3;
    logic [1:0]  cur_chip = ssm_pkg::CHIP_EEPROM;
    logic [7:0]  last_cmd = 8'h00;
    logic [7:0]  tx[$];

    always #5 clk = ~clk;

    spi_save_memory_chip_top #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .data_in  (data_in),
        .done     (done),
        .data_out (data_out),
        .stored   (stored)
    );

    save_chip_checker #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) i_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .data_in  (data_in),
        .done     (done),
        .data_out (data_out),
        .stored   (stored),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked),
        .dirty    (dirty)
    );

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom());
    endfunction

    task automatic add_byte(input logic [7:0] b);
        tx.insert(tx.size(), b);
    endtask

    task automatic send_beat(input logic m, input logic [7:0] d);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        mode <= m;
        data_in <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        beats++;
    endtask

    // sector erases walk the whole chip, so only three are let through
    task automatic send_tx();
        logic [7:0] eff;
        eff = (tx[0] == ssm_pkg::CMD_WREN || tx[0] == ssm_pkg::CMD_WRDI) ? last_cmd : tx[0];
        if (tx[0] == ssm_pkg::CMD_SEC_ERASE && sector_left == 0)
        begin
            tx[0] = ssm_pkg::CMD_PG_ERASE;
            eff = ssm_pkg::CMD_PG_ERASE;
        end
        if (eff == ssm_pkg::CMD_SEC_ERASE && tx.size() > 3)
        begin
            if (sector_left == 0)
            begin
                while (tx.size() > 3)
                    void'(tx.pop_back());
            end
            else
                sector_left--;
        end
        if (cur_chip != ssm_pkg::CHIP_NONE && tx[0] != ssm_pkg::CMD_WREN &&
            tx[0] != ssm_pkg::CMD_WRDI)
            last_cmd = tx[0];
        foreach (tx[i])
            send_beat(1'b0, tx[i]);
        send_beat(1'b1, 8'($urandom()));
        if ($urandom_range(0, 19) == 0)
            send_beat(1'b1, 8'($urandom()));
    endtask

    task automatic build_tx();
        int unsigned kind;
        int unsigned n;
        int          nab;
        int          i;
        logic [23:0] where;
        kind = $urandom_range(0, 99);
        nab = (cur_chip == ssm_pkg::CHIP_FLASH) ? 3 : (cur_chip == ssm_pkg::CHIP_TINY) ? 1 : 2;
        where = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 600));
        n = ($urandom_range(0, 119) == 0) ? $urandom_range(256, 264) : $urandom_range(1, 6);
        tx.delete();
        if (kind < 10)
            add_byte(ssm_pkg::CMD_WREN);
        else if (kind < 14)
            add_byte(ssm_pkg::CMD_WRDI);
        else if (kind < 56)
        begin
            if (kind < 34)
                add_byte((cur_chip != ssm_pkg::CHIP_EEPROM && $urandom_range(0, 1) == 1) ?
                    ssm_pkg::CMD_WRITE_HI : ssm_pkg::CMD_WRITE);
            else
                add_byte((cur_chip != ssm_pkg::CHIP_EEPROM && $urandom_range(0, 1) == 1) ?
                    ssm_pkg::CMD_READ_HI : ssm_pkg::CMD_READ);
            for (i = nab - 1; i >= 0; i--)
                add_byte(where[8*i +: 8]);
            repeat (n)
                add_byte(pick_byte());
        end
        else if (kind < 62)
        begin
            add_byte(ssm_pkg::CMD_RDSR);
            repeat ($urandom_range(1, 3))
                add_byte(pick_byte());
        end
        else if (kind < 67)
        begin
            add_byte(ssm_pkg::CMD_WRSR);
            add_byte(pick_byte());
        end
        else if (kind < 75)
        begin
            add_byte(($urandom_range(0, 19) == 0) ?
                ssm_pkg::CMD_SEC_ERASE : ssm_pkg::CMD_PG_ERASE);
            for (i = 2; i >= 0; i--)
                add_byte(where[8*i +: 8]);
            repeat ($urandom_range(0, 2))
                add_byte(pick_byte());
        end
        else if (kind < 80)
        begin
            add_byte(($urandom_range(0, 1) == 1) ? 8'h9F : 8'($urandom_range(16, 200)));
            add_byte(pick_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom()));
        end
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [1:0] chip, input int size, input logic ands,
                             input int target, input int idle);
        int n;
        settle();
        set_reg(ssm_pkg::REG_CHIP_TYPE, 32'(chip));
        set_reg(ssm_pkg::REG_SIZE_LOG2, 32'(size));
        set_reg(ssm_pkg::REG_PROG_AND, 32'(ands));
        settings++;
        cur_chip = chip;
        idle_pct = idle;
        n = 0;
        while (n < target)
        begin
            build_tx();
            n += tx.size() + 1;
            send_tx();
        end
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: eeprom with two address bytes, address wrap at the top
        tx = '{ssm_pkg::CMD_WREN};
        send_tx();
        tx = '{ssm_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hA5, 8'h5A};
        send_tx();
        tx = '{ssm_pkg::CMD_READ, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_tx();

        // flash erases, the page erase wraps within the chip
        settle();
        set_reg(ssm_pkg::REG_CHIP_TYPE, 32'(ssm_pkg::CHIP_FLASH));
        set_reg(ssm_pkg::REG_SIZE_LOG2, 32'd16);
        set_reg(ssm_pkg::REG_PROG_AND, 32'd1);
        settings++;
        cur_chip = ssm_pkg::CHIP_FLASH;
        tx = '{ssm_pkg::CMD_SEC_ERASE, 8'h00, 8'h00, 8'h00};
        send_tx();
        tx = '{ssm_pkg::CMD_PG_ERASE, 8'hFF, 8'hFF, 8'h80};
        send_tx();

        run_phase(ssm_pkg::CHIP_EEPROM, 16, 1'b1, 230, 9);
        run_phase(ssm_pkg::CHIP_TINY, 9, 1'b1, 230, 9);
        run_phase(ssm_pkg::CHIP_FLASH, 16, 1'b1, 230, 9);
        run_phase(ssm_pkg::CHIP_FLASH, 12, 1'b0, 230, 51);
        run_phase(ssm_pkg::CHIP_EEPROM, 0, 1'b0, 230, 51);
        run_phase(ssm_pkg::CHIP_NONE, 16, 1'b1, 60, 51);
        run_phase(ssm_pkg::CHIP_TINY, 26, 1'b0, 230, 0);
        run_phase(ssm_pkg::CHIP_FLASH, 31, 1'b1, 230, 0);
        run_phase(ssm_pkg::CHIP_EEPROM, 26, 1'b1, 230, 0);

        settle();
        repeat (8)
            @(negedge clk);
        $display("run covered %0d beats over %0d register settings and all chip types",
            beats, settings);
        $display("%0d answers compared, %0d of them marked as stored", checked, dirty);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #(30_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
src/ssm_pkg.sv
src/ssm_front.sv
src/ssm_queue.sv
src/ssm_back.sv
src/spi_save_memory_chip_top.sv
tb/save_chip_checker.sv
tb/tb.sv
